// File: hw/rtl/uaps_pkg.sv
// shared types and constants for the url authority and path scanner
`default_nettype none

package uaps_pkg;

   // width of the running position and the stored offsets
   localparam int PosBits = 16;

   // result status codes
   localparam logic [2:0] RSP_OK        = 3'd0;
   localparam logic [2:0] RSP_MORE      = 3'd1;
   localparam logic [2:0] RSP_STOP      = 3'd2;
   localparam logic [2:0] RSP_TOO_LARGE = 3'd3;
   localparam logic [2:0] RSP_SCHEME    = 3'd4;
   localparam logic [2:0] RSP_IPV6      = 3'd5;
   localparam logic [2:0] RSP_HOST      = 3'd6;
   localparam logic [2:0] RSP_PATH      = 3'd7;

   // flag bit positions
   localparam int FlagIpv4  = 0;
   localparam int FlagIpv6  = 1;
   localparam int FlagQuery = 2;
   localparam int FlagNorm  = 3;

   typedef struct packed {
      logic       start_req;
      logic [7:0] char_in;
      logic       last;
   } req_data_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] consumed_length;
      logic [15:0] host_offset;
      logic [7:0]  host_length;
      logic [15:0] port_value;
      logic [15:0] port_digits;
      logic [15:0] path_offset;
      logic [15:0] path_length;
      logic [15:0] decoded_path_length;
      logic [3:0]  flags;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: hw/rtl/uaps_parser.sv
// parse state registers and the per-byte next-state and summary logic
`default_nettype none

module uaps_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  uaps_pkg::req_data_type item,
   output logic                  res_valid,
   output uaps_pkg::rsp_data_type res
);
   import uaps_pkg::*;

   typedef enum logic [3:0] {
      PS_HOST_START     = 4'd0,
      PS_HOST           = 4'd1,
      PS_IP6            = 4'd2,
      PS_AFTER_HOST     = 4'd3,
      PS_PORT           = 4'd4,
      PS_PATH_START     = 4'd5,
      PS_PATH           = 4'd6,
      PS_ESC1           = 4'd7,
      PS_ESC2           = 4'd8,
      PS_QUERY          = 4'd9,
      PS_PORT_OR_SCHEME = 4'd10,
      PS_SCHEME_SLASH2  = 4'd11
   } pstate_type;

   localparam logic [7:0] ChSlash    = 8'h2f;
   localparam logic [7:0] ChColon    = 8'h3a;
   localparam logic [7:0] ChPercent  = 8'h25;
   localparam logic [7:0] ChHash     = 8'h23;
   localparam logic [7:0] ChQuestion = 8'h3f;
   localparam logic [7:0] ChDot      = 8'h2e;
   localparam logic [7:0] ChDash     = 8'h2d;
   localparam logic [7:0] ChLBracket = 8'h5b;
   localparam logic [7:0] ChRBracket = 8'h5d;
   localparam logic [7:0] HostMax    = 8'hff;
   localparam logic [7:0] Ip6Max     = 8'd47;
   localparam logic [15:0] Sat16     = 16'hffff;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
   endfunction

   function automatic logic is_name(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
   endfunction

   function automatic logic is_stop(input logic [7:0] c);
      return (c <= 8'h20) || (c == ChHash);
   endfunction

   function automatic logic [15:0] inc_sat(input logic [15:0] v);
      return (v == Sat16) ? v : v + 16'd1;
   endfunction

   pstate_type           pstate_ff, pstate_in;
   logic [PosBits-1:0]   position_ff, position_in;
   logic [7:0]           prev_ff, prev_in;
   logic [PosBits-1:0]   host_start_ff, host_start_in;
   logic [7:0]           host_count_ff, host_count_in;
   logic [15:0]          port_accum_ff, port_accum_in;
   logic [15:0]          port_count_ff, port_count_in;
   logic [PosBits-1:0]   path_start_ff, path_start_in;
   logic [15:0]          path_count_ff, path_count_in;
   logic [15:0]          decoded_ff, decoded_in;
   logic [3:0]           flag_ff, flag_in;
   logic                 finished_ff, finished_in;

   logic [7:0]           ch;
   logic                 err;
   logic                 hit;
   logic [2:0]           status;
   logic [19:0]          port_next;
   logic [PosBits-1:0]   poff;

   always_comb begin
      ch = item.char_in;
      if (item.start_req) begin
         pstate_in     = PS_HOST_START;
         position_in   = '0;
         prev_in       = '0;
         host_start_in = '0;
         host_count_in = '0;
         port_accum_in = '0;
         port_count_in = '0;
         path_start_in = '0;
         path_count_in = '0;
         decoded_in    = '0;
         flag_in       = '0;
         finished_in   = 1'b0;
      end else begin
         pstate_in     = pstate_ff;
         position_in   = position_ff;
         prev_in       = prev_ff;
         host_start_in = host_start_ff;
         host_count_in = host_count_ff;
         port_accum_in = port_accum_ff;
         port_count_in = port_count_ff;
         path_start_in = path_start_ff;
         path_count_in = path_count_ff;
         decoded_in    = decoded_ff;
         flag_in       = flag_ff;
         finished_in   = finished_ff;
      end
      err       = 1'b0;
      hit       = 1'b0;
      status    = RSP_OK;
      poff      = '0;
      port_next = ({4'd0, port_accum_in} << 3) + ({4'd0, port_accum_in} << 1)
                  + {16'd0, ch[3:0]};

      if (!finished_in) begin
         // re-dispatch chain: every hand-off moves forward in this order
         if (pstate_in == PS_HOST_START && ch != ChLBracket) begin
            if (ch == ChSlash) begin
               pstate_in = PS_PATH_START;
            end else begin
               if (is_digit(ch)) flag_in[FlagIpv4] = 1'b1;
               pstate_in = PS_HOST;
            end
         end
         if (pstate_in == PS_HOST && !(is_name(ch) || ch == ChDash || ch == ChDot)) begin
            if (host_count_in == 8'd0) begin
               err    = 1'b1;
               status = RSP_HOST;
            end else begin
               pstate_in = PS_AFTER_HOST;
            end
         end
         if (pstate_in == PS_AFTER_HOST && ch != ChColon) pstate_in = PS_PATH_START;
         if (pstate_in == PS_PORT_OR_SCHEME && ch != ChSlash) pstate_in = PS_PORT;
         if (pstate_in == PS_PORT && !is_digit(ch)) pstate_in = PS_PATH_START;
         if (pstate_in == PS_PATH_START) begin
            if (ch == ChSlash) begin
               path_start_in = position_in;
               pstate_in     = PS_PATH;
            end else begin
               err    = 1'b1;
               status = RSP_STOP;
            end
         end

         // terminal handling of the byte in the state it landed in
         if (!err) begin
            case (pstate_in)
               PS_SCHEME_SLASH2: begin
                  if (ch != ChSlash) begin
                     err    = 1'b1;
                     status = RSP_SCHEME;
                  end else begin
                     host_count_in = '0;
                     pstate_in     = PS_HOST_START;
                     host_start_in = position_in + PosBits'(1);
                  end
               end
               PS_IP6: begin
                  if (host_count_in > Ip6Max) begin
                     err    = 1'b1;
                     status = RSP_TOO_LARGE;
                  end else if (ch == ChRBracket) begin
                     pstate_in     = PS_AFTER_HOST;
                     host_count_in = host_count_in + 8'd1;
                  end else if (!(is_hex(ch) || ch == ChColon || ch == ChPercent)) begin
                     err    = 1'b1;
                     status = RSP_IPV6;
                  end else begin
                     host_count_in = host_count_in + 8'd1;
                  end
               end
               PS_HOST: begin
                  if (host_count_in == HostMax) begin
                     err    = 1'b1;
                     status = RSP_TOO_LARGE;
                  end else begin
                     if (!is_digit(ch) && ch != ChDot) flag_in[FlagIpv4] = 1'b0;
                     host_count_in = host_count_in + 8'd1;
                  end
               end
               PS_AFTER_HOST: begin
                  pstate_in = (host_start_in == '0) ? PS_PORT_OR_SCHEME : PS_PORT;
               end
               PS_PORT_OR_SCHEME: begin
                  pstate_in = PS_SCHEME_SLASH2;
               end
               PS_PORT: begin
                  if (port_next > 20'hffff) begin
                     err    = 1'b1;
                     status = RSP_TOO_LARGE;
                  end else begin
                     port_accum_in = port_next[15:0];
                     port_count_in = inc_sat(port_count_in);
                  end
               end
               PS_PATH: begin
                  if (ch == ChQuestion) begin
                     pstate_in = PS_QUERY;
                  end else if (ch != ChPercent && ch != ChSlash && ch != ChDot
                               && is_stop(ch)) begin
                     err    = 1'b1;
                     status = RSP_STOP;
                  end else begin
                     if (ch == ChPercent) begin
                        flag_in[FlagNorm] = 1'b1;
                        pstate_in         = PS_ESC1;
                     end else if ((ch == ChSlash || ch == ChDot) && prev_in == ChSlash) begin
                        flag_in[FlagNorm] = 1'b1;
                     end
                     decoded_in    = inc_sat(decoded_in);
                     path_count_in = inc_sat(path_count_in);
                  end
               end
               PS_ESC1, PS_ESC2: begin
                  if (!is_hex(ch)) begin
                     err    = 1'b1;
                     status = RSP_PATH;
                  end else begin
                     pstate_in     = (pstate_in == PS_ESC1) ? PS_ESC2 : PS_PATH;
                     path_count_in = inc_sat(path_count_in);
                  end
               end
               PS_QUERY: begin
                  if (is_stop(ch)) begin
                     err    = 1'b1;
                     status = RSP_STOP;
                  end else begin
                     flag_in[FlagQuery] = 1'b1;
                  end
               end
               default: begin
                  // host start with an opening bracket
                  pstate_in          = PS_IP6;
                  host_count_in      = host_count_in + 8'd1;
                  flag_in[FlagIpv6]  = 1'b1;
               end
            endcase
         end

         if (!err) begin
            prev_in     = ch;
            position_in = position_in + PosBits'(1);
            if ((pstate_in == PS_HOST && host_count_in != 8'd0)
                || pstate_in == PS_AFTER_HOST
                || (pstate_in == PS_PORT && port_count_in != 16'd0)
                || pstate_in == PS_PATH || pstate_in == PS_QUERY) begin
               status = RSP_OK;
            end else begin
               status = RSP_MORE;
            end
         end

         if (err || item.last) begin
            hit = 1'b1;
            if (status != RSP_MORE && !(pstate_in == PS_PATH || pstate_in == PS_QUERY)) begin
               poff = position_in;
            end else begin
               poff = path_start_in;
            end
            path_start_in = poff;
            finished_in   = 1'b1;
         end
      end

      res_valid               = step_en && hit;
      res.status              = status;
      res.consumed_length     = 16'(position_in);
      res.host_offset         = 16'(host_start_in);
      res.host_length         = host_count_in;
      res.port_value          = port_accum_in;
      res.port_digits         = port_count_in;
      res.path_offset         = 16'(poff);
      res.path_length         = path_count_in;
      res.decoded_path_length = decoded_in;
      res.flags               = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff     <= PS_HOST_START;
         position_ff   <= '0;
         prev_ff       <= '0;
         host_start_ff <= '0;
         host_count_ff <= '0;
         port_accum_ff <= '0;
         port_count_ff <= '0;
         path_start_ff <= '0;
         path_count_ff <= '0;
         decoded_ff    <= '0;
         flag_ff       <= '0;
         finished_ff   <= 1'b0;
      end else if (step_en) begin
         pstate_ff     <= pstate_in;
         position_ff   <= position_in;
         prev_ff       <= prev_in;
         host_start_ff <= host_start_in;
         host_count_ff <= host_count_in;
         port_accum_ff <= port_accum_in;
         port_count_ff <= port_count_in;
         path_start_ff <= path_start_in;
         path_count_ff <= path_count_in;
         decoded_ff    <= decoded_in;
         flag_ff       <= flag_in;
         finished_ff   <= finished_in;
      end
   end

   // once a summary is out, bytes without a start give nothing
   a_quiet_after_result: assert property (@(posedge clock) disable iff (reset)
      finished_ff && step_en && !item.start_req |-> !res_valid)
      else $error("result produced after the summary without start");

   a_result_sets_finished: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> finished_ff)
      else $error("finished not set after a result");

   // an error result leaves the position where the bad byte sits
   a_error_holds_position: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != RSP_OK && res.status != RSP_MORE
      && !item.start_req |-> res.consumed_length == 16'(position_ff))
      else $error("error result moved the position");
endmodule

`default_nettype wire

// File: hw/rtl/uaps_rsp_fifo.sv
// two-entry result buffer between the parser and the response channel
`default_nettype none

module uaps_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  uaps_pkg::rsp_data_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output uaps_pkg::rsp_data_type rsp_data
);
   import uaps_pkg::*;

   rsp_data_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result pushed into a full buffer");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("transfer out did not drain an entry");
endmodule

`default_nettype wire

// File: hw/rtl/url_authority_path_scanner_core.sv
// top level of the url authority and path scanner
//
//   channel  ports                           direction  payload
//   request  req_valid req_stall req_data    in         start_req, char_in, last
//   response rsp_valid rsp_stall rsp_data    out        status .. flags summary
//
// one byte per cycle unless req_stall holds it: a byte waits in the input register,
// where the parser resolves its whole state hand-off chain and writes the state
// registers and, on an error or the last byte, a summary into a two-entry result
// buffer; the response is valid once that summary is registered in the buffer.
// reset is synchronous and brings the parser to host start with all counts zero.
// req_stall rises only while a byte is held and the result buffer is full.
`default_nettype none

module url_authority_path_scanner_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  uaps_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output uaps_pkg::rsp_data_type rsp_data
);
   import uaps_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_data_type in_data_ff;
   logic         fifo_full;
   logic         step_en;
   logic         res_valid;
   rsp_data_type res;

   assign step_en     = in_valid_ff && !fifo_full;
   assign req_stall   = in_valid_ff && fifo_full;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   uaps_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .item      (in_data_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   uaps_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a held byte stays in place until the buffer frees an entry
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff)
      else $error("held byte dropped while stalled");

   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> step_en && !fifo_full)
      else $error("result produced without buffer room");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> fifo_full && rsp_valid)
      else $error("request stalled with buffer room left");
endmodule

`default_nettype wire

// File: test/url_authority_path_scanner_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the url authority and path scanner core

import uaps_pkg::*;

typedef enum logic [3:0] {
   SCAN_HOST_START, SCAN_HOST, SCAN_IP6, SCAN_AFTER_HOST, SCAN_PORT, SCAN_PATH_START,
   SCAN_PATH, SCAN_ESC1, SCAN_ESC2, SCAN_QUERY, SCAN_PORT_OR_SCHEME, SCAN_SCHEME_SLASH2
} scan_state_type;

class url_summary_board;
   scan_state_type     state;
   logic [PosBits-1:0] pos;
   logic [PosBits-1:0] host_start;
   logic [PosBits-1:0] path_start;
   logic [7:0]         prev_char;
   logic [7:0]         host_count;
   logic [15:0]        port_value;
   logic [15:0]        port_count;
   logic [15:0]        path_count;
   logic [15:0]        decoded_count;
   logic [3:0]         flag_bits;
   bit                 done;
   rsp_data_type       pending_summaries[$];
   int                 fails;

   function new();
      fails = 0;
      clear();
   endfunction

   function void clear();
      state = SCAN_HOST_START;
      pos = '0;
      host_start = '0;
      path_start = '0;
      prev_char = '0;
      host_count = '0;
      port_value = '0;
      port_count = '0;
      path_count = '0;
      decoded_count = '0;
      flag_bits = '0;
      done = 1'b0;
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function bit is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function bit is_name(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   // walks the state hand-off chain for one byte; returns 0 with an error code
   function bit scan_byte(logic [7:0] ch, output logic [2:0] err);
      bit          redo;
      logic [19:0] p;
      err = RSP_OK;
      for (int hop = 0; hop < 6; hop++) begin
         redo = 1'b0;
         case (state)
            SCAN_SCHEME_SLASH2: begin
               if (ch != "/") begin
                  err = RSP_SCHEME;
                  return 1'b0;
               end
               host_count = '0;
               state = SCAN_HOST_START;
               host_start = pos + 1'b1;
            end
            SCAN_IP6: begin
               if (host_count > 8'd47) begin
                  err = RSP_TOO_LARGE;
                  return 1'b0;
               end
               if (ch == "]") begin
                  state = SCAN_AFTER_HOST;
               end else if (!(is_hex(ch) || ch == ":" || ch == "%")) begin
                  err = RSP_IPV6;
                  return 1'b0;
               end
               host_count++;
            end
            SCAN_HOST: begin
               if (is_name(ch) || ch == "-" || ch == ".") begin
                  if (host_count == 8'hff) begin
                     err = RSP_TOO_LARGE;
                     return 1'b0;
                  end
                  if (!is_digit(ch) && ch != ".") flag_bits[FlagIpv4] = 1'b0;
                  host_count++;
               end else if (host_count == 0) begin
                  err = RSP_HOST;
                  return 1'b0;
               end else begin
                  state = SCAN_AFTER_HOST;
                  redo = 1'b1;
               end
            end
            SCAN_AFTER_HOST: begin
               if (ch == ":") begin
                  // a colon right after a host at offset zero may open a scheme
                  state = (host_start == 0) ? SCAN_PORT_OR_SCHEME : SCAN_PORT;
               end else begin
                  state = SCAN_PATH_START;
                  redo = 1'b1;
               end
            end
            SCAN_PORT_OR_SCHEME: begin
               if (ch == "/") begin
                  state = SCAN_SCHEME_SLASH2;
               end else begin
                  state = SCAN_PORT;
                  redo = 1'b1;
               end
            end
            SCAN_PORT: begin
               if (!is_digit(ch)) begin
                  state = SCAN_PATH_START;
                  redo = 1'b1;
               end else begin
                  p = 20'(port_value) * 20'd10 + 20'(ch - 8'h30);
                  if (p > 20'hffff) begin
                     err = RSP_TOO_LARGE;
                     return 1'b0;
                  end
                  port_value = p[15:0];
                  port_count = bump(port_count);
               end
            end
            SCAN_PATH_START: begin
               if (ch != "/") begin
                  err = RSP_STOP;
                  return 1'b0;
               end
               path_start = pos;
               state = SCAN_PATH;
               redo = 1'b1;
            end
            SCAN_PATH: begin
               if (ch == "?") begin
                  state = SCAN_QUERY;
               end else begin
                  if (ch == "%") begin
                     flag_bits[FlagNorm] = 1'b1;
                     state = SCAN_ESC1;
                  end else if (ch == "/" || ch == ".") begin
                     if (prev_char == "/") flag_bits[FlagNorm] = 1'b1;
                  end else if (ch <= 8'h20 || ch == "#") begin
                     err = RSP_STOP;
                     return 1'b0;
                  end
                  decoded_count = bump(decoded_count);
                  path_count = bump(path_count);
               end
            end
            SCAN_ESC1, SCAN_ESC2: begin
               if (!is_hex(ch)) begin
                  err = RSP_PATH;
                  return 1'b0;
               end
               state = (state == SCAN_ESC1) ? SCAN_ESC2 : SCAN_PATH;
               path_count = bump(path_count);
            end
            SCAN_QUERY: begin
               if (ch <= 8'h20 || ch == "#") begin
                  err = RSP_STOP;
                  return 1'b0;
               end
               flag_bits[FlagQuery] = 1'b1;
            end
            default: begin
               if (ch == "[") begin
                  state = SCAN_IP6;
                  host_count++;
                  flag_bits[FlagIpv6] = 1'b1;
               end else if (ch == "/") begin
                  state = SCAN_PATH_START;
                  redo = 1'b1;
               end else begin
                  if (is_digit(ch)) flag_bits[FlagIpv4] = 1'b1;
                  state = SCAN_HOST;
                  redo = 1'b1;
               end
            end
         endcase
         if (!redo) return 1'b1;
      end
      return 1'b1;
   endfunction

   function void note_byte(req_data_type d);
      logic [2:0]         code;
      logic [PosBits-1:0] poff;
      rsp_data_type       s;
      if (d.start_req) clear();
      if (done) return;
      if (scan_byte(d.char_in, code)) begin
         prev_char = d.char_in;
         pos = pos + 1'b1;
         if (!d.last) return;
         if ((state == SCAN_HOST && host_count != 0) || state == SCAN_AFTER_HOST
             || (state == SCAN_PORT && port_count != 0)
             || state == SCAN_PATH || state == SCAN_QUERY)
            code = RSP_OK;
         else
            code = RSP_MORE;
      end
      poff = path_start;
      if (code != RSP_MORE && !(state == SCAN_PATH || state == SCAN_QUERY)) poff = pos;
      path_start = poff;
      done = 1'b1;
      s.status = code;
      s.consumed_length = 16'(pos);
      s.host_offset = 16'(host_start);
      s.host_length = host_count;
      s.port_value = port_value;
      s.port_digits = port_count;
      s.path_offset = 16'(poff);
      s.path_length = path_count;
      s.decoded_path_length = decoded_count;
      s.flags = flag_bits;
      pending_summaries.push_back(s);
   endfunction

   function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         fails++;
         if (fails <= 10) $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      end
   endfunction

   function void check_summary(rsp_data_type got);
      rsp_data_type want;
      if (pending_summaries.size() == 0) begin
         fails++;
         if (fails <= 10) $display("summary with status %0d arrived unexpectedly", got.status);
         return;
      end
      want = pending_summaries.pop_front();
      compare("status", want.status, got.status);
      compare("consumed_length", want.consumed_length, got.consumed_length);
      compare("host_offset", want.host_offset, got.host_offset);
      compare("host_length", want.host_length, got.host_length);
      compare("port_value", want.port_value, got.port_value);
      compare("port_digits", want.port_digits, got.port_digits);
      compare("path_offset", want.path_offset, got.path_offset);
      compare("path_length", want.path_length, got.path_length);
      compare("decoded_path_length", want.decoded_path_length, got.decoded_path_length);
      compare("flags", want.flags, got.flags);
   endfunction
endclass

module url_authority_path_scanner_core_tb;

   localparam int CycleLimit = 1_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;

   url_summary_board board;
   logic [7:0]       url_q[$];
   int               send_gap_pct = 0;
   int               recv_stall_pct = 0;
   int               cycle_count = 0;

   url_authority_path_scanner_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("url_authority_path_scanner_core test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_byte(req_data);
         if (rsp_valid && !rsp_stall) board.check_summary(rsp_data);
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic start_bit, input logic [7:0] ch, input logic last_bit);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{start_req: start_bit, char_in: ch, last: last_bit};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic first_start, input logic fin);
      for (int i = 0; i < s.len(); i++)
         send_byte(i == 0 ? first_start : 1'b0, s[i], fin && i == s.len() - 1);
   endtask

   task automatic send_url(input logic fin);
      for (int i = 0; i < url_q.size(); i++)
         send_byte(i == 0, url_q[i], fin && i == url_q.size() - 1);
      // stray bytes after the url, dropped when a summary already went out
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(1, 3)) send_byte(1'b0, $urandom_range(255), $urandom_range(1));
   endtask

   task automatic wait_for_summaries();
      req_valid <= 1'b0;
      while (board.pending_summaries.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) url_q.push_back(s[i]);
   endfunction

   function automatic void build_url();
      int n;
      int v;
      url_q.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 12)) url_q.push_back($urandom_range(255));
         return;
      end
      if ($urandom_range(99) < 30) begin
         repeat ($urandom_range(1, 5)) url_q.push_back(pick("httpsfwxyz1"));
         add_text($urandom_range(9) == 0 ? ":/x" : "://");
      end
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            n = ($urandom_range(19) == 0) ? $urandom_range(250, 260) : $urandom_range(1, 20);
            repeat (n) url_q.push_back(pick("abcxyzABZ0189_-.."));
         end
         4, 5: begin
            add_text($sformatf("%0d.%0d.%0d.%0d", $urandom_range(255), $urandom_range(255),
                               $urandom_range(999), $urandom_range(255)));
            if ($urandom_range(3) == 0) url_q.push_back(pick("a-_Z"));
         end
         6, 7: begin
            n = ($urandom_range(9) == 0) ? $urandom_range(44, 50) : $urandom_range(0, 12);
            url_q.push_back("[");
            repeat (n) url_q.push_back(pick("0123456789abcdefABCDEF:::%g"));
            if ($urandom_range(9) != 0) url_q.push_back("]");
         end
         default: ;
      endcase
      if ($urandom_range(99) < 40) begin
         url_q.push_back(":");
         case ($urandom_range(5))
            0: v = $urandom_range(9);
            1: v = 65535;
            2: v = 65536;
            3: v = $urandom_range(99999);
            4: v = $urandom_range(655359);
            default: v = $urandom_range(1000);
         endcase
         if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) url_q.push_back("0");
         if ($urandom_range(9) != 0) add_text($sformatf("%0d", v));
      end
      if ($urandom_range(99) < 75) begin
         url_q.push_back("/");
         repeat ($urandom_range(0, 25)) begin
            v = $urandom_range(99);
            if (v < 8) begin
               url_q.push_back("%");
               url_q.push_back(pick("0123456789abcdefABCDEF"));
               url_q.push_back(pick("0123456789abcdefABCDEF"));
            end else if (v < 11) begin
               url_q.push_back("%");
               url_q.push_back(pick("0aFgz%/"));
            end else begin
               url_q.push_back(pick("abz09-_~:@//..+"));
            end
         end
         if ($urandom_range(99) < 30) begin
            url_q.push_back("?");
            repeat ($urandom_range(0, 8)) url_q.push_back(pick("ab=&?/%.9"));
         end
      end
      if ($urandom_range(99) < 8) begin
         url_q.push_back(pick(" #\t"));
         repeat ($urandom_range(0, 3)) url_q.push_back(pick("xy/"));
      end
      if (url_q.size() == 0) url_q.push_back(pick("/a1["));
      if ($urandom_range(99) < 10) url_q[$urandom_range(url_q.size() - 1)] = $urandom_range(255);
   endfunction

   task automatic run_phase(input int gap_pct, input int stall_pct, input int target);
      int sent;
      sent = 0;
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      while (sent < target) begin
         build_url();
         send_url($urandom_range(99) < 92);
         sent += url_q.size();
      end
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: dotted ipv4 with port, bracketed host, bad escape, ignored byte,
      // bare query mark, scheme, host errors on the smallest and largest byte
      send_text("1.2:9/.", 1'b0, 1'b1);
      send_text("[f%]", 1'b1, 1'b1);
      send_text("/%4g", 1'b1, 1'b1);
      send_byte(1'b0, "x", 1'b1);
      send_text("/?", 1'b1, 1'b1);
      send_text("h://x", 1'b1, 1'b1);
      send_byte(1'b1, 8'h00, 1'b0);
      send_byte(1'b1, 8'hff, 1'b1);
      wait_for_summaries();

      run_phase(9, 77, 650);
      wait_for_summaries();
      run_phase(77, 9, 650);
      wait_for_summaries();
      run_phase(0, 0, 650);

      wait_for_summaries();
      repeat (8) @(posedge clock);
      if (board.fails == 0 && board.pending_summaries.size() == 0)
         $display("url_authority_path_scanner_core test passed");
      else
         $display("url_authority_path_scanner_core test failed");
      $finish;
   end

endmodule

// File: url_authority_path_scanner_core.f
hw/rtl/uaps_pkg.sv
hw/rtl/uaps_parser.sv
hw/rtl/uaps_rsp_fifo.sv
hw/rtl/url_authority_path_scanner_core.sv
test/url_authority_path_scanner_core_tb.sv
